// ===== design/s2cd_pkg.sv =====
package s2cd_pkg;

    localparam int CountWidth = 32;

    localparam logic [CountWidth-1:0] UnixOffset2000 = CountWidth'(946684800);

    localparam logic [5:0] SecsPerMinute = 6'd60;
    localparam logic [5:0] MinsPerHour   = 6'd60;
    localparam logic [5:0] HoursPerDay   = 6'd24;
    localparam logic [8:0] DaysPerYear   = 9'd365;

    localparam logic [3:0] MonthFeb = 4'd2;
    localparam logic [3:0] MonthDec = 4'd12;

    localparam int InDataWidth  = 32;
    localparam int OutDataWidth = 40;

    // reciprocals for exact division of a 32-bit value by 60 and by 24
    localparam logic [InDataWidth-1:0] RecipDiv60 = 32'h8888_8889;
    localparam int                     ShiftDiv60 = 37;
    localparam logic [InDataWidth-1:0] RecipDiv24 = 32'hAAAA_AAAB;
    localparam int                     ShiftDiv24 = 36;

    // days in a month, february without the leap day
    function automatic logic [4:0] month_len(input logic [3:0] month);
        logic [4:0] len;
        case (month)
            4'd2:                  len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:               len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== design/seconds_to_calendar_date.sv =====
// sequence from input transaction to result valid: in unix mode a subtraction of the 2000
// offset (a unix input before 2000 goes straight to the result), a multiply and a remainder
// step for each division by 60, 60 and 24, a step per year and per month tested, a result load
// throughput: one transaction at a time, the next is accepted in the cycle after the result
// register loads; a result waiting on m_axis_tready holds the block
// reset: i_rst_n synchronous active low; clears the sequencer, result valid and mode register
module seconds_to_calendar_date (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // config write
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic                               i_cfg_data,      // unix_epoch_mode
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [s2cd_pkg::InDataWidth-1:0]   s_axis_tdata,    // seconds_count
    // output stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // second_of_minute, minute_of_hour, hour_of_day, years_after_2000, month_number,
    // day_number, zero fill
    output logic [s2cd_pkg::OutDataWidth-1:0]  m_axis_tdata,
    output logic                               m_axis_tuser     // before_origin
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_OFFS  = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_REM   = 3'd3;
    localparam logic [2:0] ST_YEAR  = 3'd4;
    localparam logic [2:0] ST_MONTH = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    localparam logic [1:0] STG_SEC  = 2'd0;
    localparam logic [1:0] STG_MIN  = 2'd1;
    localparam logic [1:0] STG_HOUR = 2'd2;

    localparam int CW = s2cd_pkg::CountWidth;
    localparam int MW = s2cd_pkg::InDataWidth;
    localparam int PW = 2 * MW;

    logic [2:0]    r_state, n_state;
    logic          r_mode;
    logic [CW-1:0] r_q, n_q;
    logic [CW-1:0] r_quo, n_quo;
    logic [1:0]    r_stage, n_stage;
    logic [5:0]    r_sec, n_sec;
    logic [5:0]    r_min, n_min;
    logic [4:0]    r_hour, n_hour;
    logic [7:0]    r_year, n_year;
    logic [3:0]    r_month, n_month;
    logic          r_before, n_before;

    logic          r_out_valid;
    logic [s2cd_pkg::OutDataWidth-1:0] r_out_data;
    logic          r_out_user;

    // shared subtractor
    logic [CW-1:0] sub_a, sub_b;
    logic [CW:0]   sub_diff;
    logic          sub_borrow;
    logic [5:0]    divisor;
    logic [MW-1:0] recip;
    logic [PW-1:0] mul_prod;
    logic [CW-1:0] mul_quo;
    logic [CW-1:0] quo_times;
    logic          leap;
    logic [8:0]    year_len;
    logic [4:0]    mon_len;
    logic          load_out;

    assign leap      = (r_year[1:0] == 2'b00);
    assign year_len  = s2cd_pkg::DaysPerYear + {8'd0, leap};
    assign mon_len   = s2cd_pkg::month_len(r_month)
                     + {4'd0, (r_month == s2cd_pkg::MonthFeb) && leap};

    always_comb begin
        case (r_stage)
            STG_SEC: begin
                divisor = s2cd_pkg::SecsPerMinute;
                recip   = s2cd_pkg::RecipDiv60;
            end
            STG_MIN: begin
                divisor = s2cd_pkg::MinsPerHour;
                recip   = s2cd_pkg::RecipDiv60;
            end
            default: begin
                divisor = s2cd_pkg::HoursPerDay;
                recip   = s2cd_pkg::RecipDiv24;
            end
        endcase
    end

    // quotient by reciprocal multiplication, remainder through the subtractor
    assign mul_prod  = PW'(r_q[MW-1:0]) * PW'(recip);
    assign mul_quo   = (r_stage == STG_HOUR) ? CW'(mul_prod >> s2cd_pkg::ShiftDiv24)
                                             : CW'(mul_prod >> s2cd_pkg::ShiftDiv60);
    assign quo_times = r_quo * CW'(divisor);

    always_comb begin
        sub_a = r_q;
        sub_b = '0;
        unique case (r_state)
            ST_OFFS:  sub_b = s2cd_pkg::UnixOffset2000;
            ST_REM:   sub_b = quo_times;
            ST_YEAR:  sub_b = CW'(year_len);
            ST_MONTH: sub_b = CW'(mon_len);
            default:  sub_b = '0;
        endcase
    end

    assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_borrow = sub_diff[CW];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign load_out      = (r_state == ST_DONE) && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_state  = r_state;
        n_q      = r_q;
        n_quo    = r_quo;
        n_stage  = r_stage;
        n_sec    = r_sec;
        n_min    = r_min;
        n_hour   = r_hour;
        n_year   = r_year;
        n_month  = r_month;
        n_before = r_before;
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_q      = CW'(s_axis_tdata);
                    n_stage  = STG_SEC;
                    n_year   = '0;
                    n_month  = 4'd1;
                    n_before = 1'b0;
                    n_state  = r_mode ? ST_OFFS : ST_MUL;
                end
            end
            ST_OFFS: begin
                if (sub_borrow) begin
                    n_before = 1'b1;
                    n_state  = ST_DONE;
                end else begin
                    n_q     = sub_diff[CW-1:0];
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_quo   = mul_quo;
                n_state = ST_REM;
            end
            ST_REM: begin
                n_q = r_quo;
                case (r_stage)
                    STG_SEC: n_sec  = sub_diff[5:0];
                    STG_MIN: n_min  = sub_diff[5:0];
                    default: n_hour = sub_diff[4:0];
                endcase
                if (r_stage == STG_HOUR) begin
                    n_state = ST_YEAR;
                end else begin
                    n_stage = r_stage + 1'b1;
                    n_state = ST_MUL;
                end
            end
            ST_YEAR: begin
                if (sub_borrow) begin
                    n_state = ST_MONTH;
                end else begin
                    n_q    = sub_diff[CW-1:0];
                    n_year = r_year + 1'b1;
                end
            end
            ST_MONTH: begin
                if (sub_borrow || r_month == s2cd_pkg::MonthDec) begin
                    n_state = ST_DONE;
                end else begin
                    n_q     = sub_diff[CW-1:0];
                    n_month = r_month + 1'b1;
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q      <= n_q;
        r_quo    <= n_quo;
        r_stage  <= n_stage;
        r_sec    <= n_sec;
        r_min    <= n_min;
        r_hour   <= n_hour;
        r_year   <= n_year;
        r_month  <= n_month;
        r_before <= n_before;
        if (load_out) begin
            r_out_user <= r_before;
            if (r_before) begin
                r_out_data <= '0;
            end else begin
                r_out_data <= {6'd0, r_q[4:0] + 5'd1, r_month, r_year, r_hour, r_min, r_sec};
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

`ifndef SYNTHESIS
    a_before_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("before_origin result with nonzero fields");

    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            m_axis_tdata[28:25] != 4'd0 && m_axis_tdata[28:25] <= s2cd_pkg::MonthDec)
        else $error("month out of range");

    a_day_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[33:29] != 5'd0)
        else $error("day of month is zero");

    a_div_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL || r_state == ST_REM) |-> r_stage <= STG_HOUR)
        else $error("divider stage out of range");
`endif

endmodule
